FILE: src/hgbs_pkg.sv
package hgbs_pkg;

    localparam int MagFracBitsDefault = 6;
    localparam int CoefFrac           = 12;
    localparam int CoefWidth          = 14;
    localparam int ProdWidth          = 8 + CoefWidth;
    localparam int MagMax             = 65535;

    localparam logic [7:0] DEG_10  = 8'd10;
    localparam logic [7:0] DEG_30  = 8'd30;
    localparam logic [7:0] DEG_50  = 8'd50;
    localparam logic [7:0] DEG_70  = 8'd70;
    localparam logic [7:0] DEG_90  = 8'd90;
    localparam logic [7:0] DEG_170 = 8'd170;

    localparam logic [16:0] K70_DY = 17'd91;
    localparam logic [16:0] K70_DX = 17'd250;
    localparam logic [16:0] K50_DY = 17'd193;
    localparam logic [16:0] K50_DX = 17'd230;
    localparam logic [16:0] K30_DY = 17'd97;
    localparam logic [16:0] K30_DX = 17'd56;
    localparam logic [16:0] K10_DY = 17'd244;
    localparam logic [16:0] K10_DX = 17'd43;

    typedef enum logic [2:0] {
        PAIR_70_90  = 3'd0,
        PAIR_50_70  = 3'd1,
        PAIR_30_50  = 3'd2,
        PAIR_10_30  = 3'd3,
        PAIR_170_10 = 3'd4,
        PAIR_90_90  = 3'd5
    } pair_t;

    typedef struct packed {
        logic [7:0] right_pixel;
        logic [7:0] left_pixel;
        logic [7:0] lower_pixel;
        logic [7:0] upper_pixel;
    } pix_t;

    typedef struct packed {
        logic [7:0]  first_bin_degrees;
        logic [7:0]  second_bin_degrees;
        logic [15:0] first_magnitude;
        logic [15:0] second_magnitude;
    } grad_t;

    typedef struct packed {
        logic [7:0] dx;
        logic [7:0] dy;
    } diff_t;

    typedef struct packed {
        pair_t      sel;
        logic [7:0] dx;
        logic [7:0] dy;
    } cls_t;

    typedef struct packed {
        pair_t                  sel;
        logic [7:0]             dy;
        logic [ProdWidth-1:0]   a1;
        logic [ProdWidth-1:0]   b1;
        logic [ProdWidth-1:0]   a2;
        logic [ProdWidth-1:0]   b2;
    } prod_t;

    typedef struct packed {
        logic [CoefWidth-1:0] s2;
        logic [CoefWidth-1:0] c2;
        logic [CoefWidth-1:0] c1;
        logic [CoefWidth-1:0] s1;
    } coef_t;

    function automatic coef_t pair_coef(input pair_t sel);
        coef_t c;
        unique case (sel)
            PAIR_70_90:  c = '{s2: 14'd11976, c2: 14'd0,     c1: 14'd4096,  s1: 14'd11254};
            PAIR_50_70:  c = '{s2: 14'd11254, c2: 14'd4096,  c1: 14'd7698,  s1: 14'd9174};
            PAIR_30_50:  c = '{s2: 14'd9174,  c2: 14'd7698,  c1: 14'd10371, s1: 14'd5988};
            PAIR_10_30:  c = '{s2: 14'd5988,  c2: 14'd10371, c1: 14'd11794, s1: 14'd2080};
            PAIR_170_10: c = '{s2: 14'd2080,  c2: 14'd11794, c1: 14'd11794, s1: 14'd2080};
            default:     c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] first_deg(input pair_t sel);
        logic [7:0] d;
        unique case (sel)
            PAIR_70_90:  d = DEG_70;
            PAIR_50_70:  d = DEG_50;
            PAIR_30_50:  d = DEG_30;
            PAIR_10_30:  d = DEG_10;
            PAIR_90_90:  d = DEG_90;
            default:     d = DEG_170;
        endcase
        return d;
    endfunction

    function automatic logic [7:0] second_deg(input pair_t sel);
        logic [7:0] d;
        unique case (sel)
            PAIR_70_90:  d = DEG_90;
            PAIR_50_70:  d = DEG_70;
            PAIR_30_50:  d = DEG_50;
            PAIR_10_30:  d = DEG_30;
            PAIR_90_90:  d = DEG_90;
            default:     d = DEG_10;
        endcase
        return d;
    endfunction

endpackage

FILE: src/hgbs_diff.sv
module hgbs_diff (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_stall,
    input  hgbs_pkg::pix_t   up_data,
    output logic             dn_valid,
    input  logic             dn_stall,
    output hgbs_pkg::diff_t  dn_data
);

    logic            valid_reg;
    hgbs_pkg::diff_t data_reg;
    hgbs_pkg::diff_t data_next;

    always_comb
    begin
        data_next.dx = (up_data.right_pixel > up_data.left_pixel)
                     ? up_data.right_pixel - up_data.left_pixel : 8'd0;
        data_next.dy = (up_data.lower_pixel > up_data.upper_pixel)
                     ? up_data.lower_pixel - up_data.upper_pixel : 8'd0;
    end

    assign up_stall = valid_reg && dn_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

FILE: src/hgbs_classify.sv
module hgbs_classify (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_stall,
    input  hgbs_pkg::diff_t  up_data,
    output logic             dn_valid,
    input  logic             dn_stall,
    output hgbs_pkg::cls_t   dn_data
);

    logic           valid_reg;
    hgbs_pkg::cls_t data_reg;
    hgbs_pkg::cls_t data_next;
    logic [16:0]    dx_w;
    logic [16:0]    dy_w;

    assign dx_w = 17'(up_data.dx);
    assign dy_w = 17'(up_data.dy);

    always_comb
    begin
        data_next.dx = up_data.dx;
        data_next.dy = up_data.dy;
        priority if (up_data.dy == 8'd0)
            data_next.sel = hgbs_pkg::PAIR_170_10;
        else if (up_data.dx == 8'd0)
            data_next.sel = hgbs_pkg::PAIR_90_90;
        else if (dy_w * hgbs_pkg::K70_DY > dx_w * hgbs_pkg::K70_DX)
            data_next.sel = hgbs_pkg::PAIR_70_90;
        else if (dy_w * hgbs_pkg::K50_DY > dx_w * hgbs_pkg::K50_DX)
            data_next.sel = hgbs_pkg::PAIR_50_70;
        else if (dy_w * hgbs_pkg::K30_DY > dx_w * hgbs_pkg::K30_DX)
            data_next.sel = hgbs_pkg::PAIR_30_50;
        else if (dy_w * hgbs_pkg::K10_DY > dx_w * hgbs_pkg::K10_DX)
            data_next.sel = hgbs_pkg::PAIR_10_30;
        else
            data_next.sel = hgbs_pkg::PAIR_170_10;
    end

    assign up_stall = valid_reg && dn_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

FILE: src/hgbs_mult.sv
module hgbs_mult (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_stall,
    input  hgbs_pkg::cls_t   up_data,
    output logic             dn_valid,
    input  logic             dn_stall,
    output hgbs_pkg::prod_t  dn_data
);

    localparam int PW = hgbs_pkg::ProdWidth;

    logic            valid_reg;
    hgbs_pkg::prod_t data_reg;
    hgbs_pkg::prod_t data_next;
    hgbs_pkg::coef_t cf;
    logic [PW-1:0]   dx_w;
    logic [PW-1:0]   dy_w;

    assign cf   = hgbs_pkg::pair_coef(up_data.sel);
    assign dx_w = PW'(up_data.dx);
    assign dy_w = PW'(up_data.dy);

    always_comb
    begin
        data_next.sel = up_data.sel;
        data_next.dy  = up_data.dy;
        data_next.a1  = dx_w * PW'(cf.s2);
        data_next.b1  = dy_w * PW'(cf.c2);
        data_next.a2  = dy_w * PW'(cf.c1);
        data_next.b2  = dx_w * PW'(cf.s1);
    end

    assign up_stall = valid_reg && dn_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

FILE: src/hgbs_round.sv
module hgbs_round #(
    parameter int MAG_FRAC_BITS = hgbs_pkg::MagFracBitsDefault
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_stall,
    input  hgbs_pkg::prod_t  up_data,
    output logic             dn_valid,
    input  logic             dn_stall,
    output hgbs_pkg::grad_t  dn_data
);

    localparam int         PW  = hgbs_pkg::ProdWidth;
    localparam int         NW  = PW + 2;
    localparam int         SH  = hgbs_pkg::CoefFrac - MAG_FRAC_BITS;
    localparam logic [NW-1:0] RND = NW'((1 << SH) >> 1);
    localparam logic [NW-1:0] SAT = NW'(hgbs_pkg::MagMax);
    localparam int         VW  = 8 + hgbs_pkg::CoefFrac;

    function automatic logic [15:0] to_mag(input logic signed [NW-1:0] num);
        logic [NW-1:0] v;
        v = (NW'(unsigned'(num)) + RND) >> SH;
        if (num <= 0)
            return 16'd0;
        else if (v > SAT)
            return 16'hFFFF;
        else
            return v[15:0];
    endfunction

    logic                   valid_reg;
    hgbs_pkg::grad_t        data_reg;
    hgbs_pkg::grad_t        data_next;
    logic signed [NW-1:0]   num1;
    logic signed [NW-1:0]   num2;
    logic [VW-1:0]          vert;

    assign num1 = signed'(NW'(up_data.a1)) - signed'(NW'(up_data.b1));
    assign num2 = (up_data.sel == hgbs_pkg::PAIR_170_10)
                ? signed'(NW'(up_data.a2)) + signed'(NW'(up_data.b2))
                : signed'(NW'(up_data.a2)) - signed'(NW'(up_data.b2));
    assign vert = VW'(up_data.dy) << MAG_FRAC_BITS;

    always_comb
    begin
        data_next.first_bin_degrees  = hgbs_pkg::first_deg(up_data.sel);
        data_next.second_bin_degrees = hgbs_pkg::second_deg(up_data.sel);
        if (up_data.sel == hgbs_pkg::PAIR_90_90)
        begin
            data_next.first_magnitude  = (vert > VW'(hgbs_pkg::MagMax))
                                       ? 16'hFFFF : vert[15:0];
            data_next.second_magnitude = 16'd0;
        end
        else
        begin
            data_next.first_magnitude  = to_mag(num1);
            data_next.second_magnitude = to_mag(num2);
        end
    end

    assign up_stall = valid_reg && dn_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

FILE: src/hog_gradient_bin_split.sv
// Nine-bin HOG orientation binning for one pixel per clock. A request on pix carries the four
// neighbours of a cell pixel; the block forms the clamped differences dx and dy, picks two
// adjacent orientation bins by constant ratio tests, and splits the gradient into two unsigned
// magnitudes with MAG_FRAC_BITS fraction bits that saturate at 65535. Every result leaves on
// grad after passing four register stages (difference, bin choice, constant multiplies,
// combine and round), and a new request is taken every cycle that pix is not stalled. Empty
// stages fill while grad is stalled, so pix stalls only when all four stages hold requests.
module hog_gradient_bin_split #(
    parameter int MAG_FRAC_BITS = hgbs_pkg::MagFracBitsDefault
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pix_valid,
    output logic             pix_stall,
    input  hgbs_pkg::pix_t   pix,
    output logic             grad_valid,
    input  logic             grad_stall,
    output hgbs_pkg::grad_t  grad
);

    logic            d_valid;
    logic            d_stall;
    hgbs_pkg::diff_t d_data;
    logic            c_valid;
    logic            c_stall;
    hgbs_pkg::cls_t  c_data;
    logic            m_valid;
    logic            m_stall;
    hgbs_pkg::prod_t m_data;

    hgbs_diff u_diff (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pix_valid),
        .up_stall (pix_stall),
        .up_data  (pix),
        .dn_valid (d_valid),
        .dn_stall (d_stall),
        .dn_data  (d_data)
    );

    hgbs_classify u_classify (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (d_valid),
        .up_stall (d_stall),
        .up_data  (d_data),
        .dn_valid (c_valid),
        .dn_stall (c_stall),
        .dn_data  (c_data)
    );

    hgbs_mult u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (c_valid),
        .up_stall (c_stall),
        .up_data  (c_data),
        .dn_valid (m_valid),
        .dn_stall (m_stall),
        .dn_data  (m_data)
    );

    hgbs_round #(
        .MAG_FRAC_BITS (MAG_FRAC_BITS)
    ) u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (m_valid),
        .up_stall (m_stall),
        .up_data  (m_data),
        .dn_valid (grad_valid),
        .dn_stall (grad_stall),
        .dn_data  (grad)
    );

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> (d_valid && c_valid && m_valid && grad_valid && grad_stall))
        else $error("pix stalled with a free stage");

    a_vertical_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (grad_valid && grad.first_bin_degrees == hgbs_pkg::DEG_90)
        |-> (grad.second_bin_degrees == hgbs_pkg::DEG_90 && grad.second_magnitude == 16'd0))
        else $error("vertical result with nonzero second share");

    a_wrap_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (grad_valid && grad.first_bin_degrees == hgbs_pkg::DEG_170)
        |-> (grad.second_bin_degrees == hgbs_pkg::DEG_10))
        else $error("bin 170 not paired with bin 10");

    a_second_not_170: assert property (@(posedge clk) disable iff (!rst_n)
        grad_valid |-> (grad.second_bin_degrees != hgbs_pkg::DEG_170))
        else $error("second bin is 170");

endmodule

FILE: verif/gradient_split_checker.sv
module gradient_split_checker #(
    parameter int MAG_FRAC_BITS = hgbs_pkg::MagFracBitsDefault
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pix_valid,
    input  logic            pix_stall,
    input  hgbs_pkg::pix_t  pix,
    input  logic            grad_valid,
    input  logic            grad_stall,
    input  hgbs_pkg::grad_t grad,
    output int              errors,
    output int              outstanding,
    output int              compared
);

    hgbs_pkg::grad_t expected_grads[$];

    function automatic logic [15:0] round_magnitude(input longint num);
        longint v;
        int     sh;
        sh = hgbs_pkg::CoefFrac - MAG_FRAC_BITS;
        if (num <= 0)
            return 16'd0;
        v = num;
        if (sh > 0)
            v = (v + (longint'(1) << (sh - 1))) >>> sh;
        return (v > longint'(hgbs_pkg::MagMax)) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic hgbs_pkg::grad_t split_gradient(input hgbs_pkg::pix_t p);
        longint          dx;
        longint          dy;
        longint          s2;
        longint          c2;
        longint          c1;
        longint          s1;
        longint          vert;
        hgbs_pkg::pair_t sel;
        hgbs_pkg::grad_t g;
        dx = longint'(p.right_pixel) - longint'(p.left_pixel);
        dy = longint'(p.lower_pixel) - longint'(p.upper_pixel);
        if (dx < 0)
            dx = 0;
        if (dy < 0)
            dy = 0;

        if (dy != 0 && dx == 0)
            sel = hgbs_pkg::PAIR_90_90;
        else if (dy == 0)
            sel = hgbs_pkg::PAIR_170_10;
        else if (dy * 91 > dx * 250)
            sel = hgbs_pkg::PAIR_70_90;
        else if (dy * 193 > dx * 230)
            sel = hgbs_pkg::PAIR_50_70;
        else if (dy * 97 > dx * 56)
            sel = hgbs_pkg::PAIR_30_50;
        else if (dy * 244 > dx * 43)
            sel = hgbs_pkg::PAIR_10_30;
        else
            sel = hgbs_pkg::PAIR_170_10;

        s2 = 0;
        c2 = 0;
        c1 = 0;
        s1 = 0;
        case (sel)
            hgbs_pkg::PAIR_70_90:
            begin
                g.first_bin_degrees  = hgbs_pkg::DEG_70;
                g.second_bin_degrees = hgbs_pkg::DEG_90;
                s2 = 11976; c2 = 0;     c1 = 4096;  s1 = 11254;
            end
            hgbs_pkg::PAIR_50_70:
            begin
                g.first_bin_degrees  = hgbs_pkg::DEG_50;
                g.second_bin_degrees = hgbs_pkg::DEG_70;
                s2 = 11254; c2 = 4096;  c1 = 7698;  s1 = 9174;
            end
            hgbs_pkg::PAIR_30_50:
            begin
                g.first_bin_degrees  = hgbs_pkg::DEG_30;
                g.second_bin_degrees = hgbs_pkg::DEG_50;
                s2 = 9174;  c2 = 7698;  c1 = 10371; s1 = 5988;
            end
            hgbs_pkg::PAIR_10_30:
            begin
                g.first_bin_degrees  = hgbs_pkg::DEG_10;
                g.second_bin_degrees = hgbs_pkg::DEG_30;
                s2 = 5988;  c2 = 10371; c1 = 11794; s1 = 2080;
            end
            hgbs_pkg::PAIR_90_90:
            begin
                g.first_bin_degrees  = hgbs_pkg::DEG_90;
                g.second_bin_degrees = hgbs_pkg::DEG_90;
            end
            default:
            begin
                // sine of 170 degrees reflects into the negative
                g.first_bin_degrees  = hgbs_pkg::DEG_170;
                g.second_bin_degrees = hgbs_pkg::DEG_10;
                s2 = 2080;  c2 = 11794; c1 = 11794; s1 = -2080;
            end
        endcase

        if (sel == hgbs_pkg::PAIR_90_90)
        begin
            vert = dy << MAG_FRAC_BITS;
            g.first_magnitude  = (vert > longint'(hgbs_pkg::MagMax)) ? 16'hFFFF : vert[15:0];
            g.second_magnitude = 16'd0;
        end
        else
        begin
            g.first_magnitude  = round_magnitude(dx * s2 - dy * c2);
            g.second_magnitude = round_magnitude(dy * c1 - dx * s1);
        end
        return g;
    endfunction

    function automatic int field_differs(input string name, input int want, input int got);
        if (want == got)
            return 0;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hgbs_pkg::grad_t want;
        int              bad;
        if (!rst_n)
        begin
            expected_grads.delete();
            errors      <= 0;
            outstanding <= 0;
            compared    <= 0;
        end
        else
        begin
            bad = 0;
            if (grad_valid && !grad_stall)
            begin
                if (expected_grads.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h", $time, grad);
                    bad = 1;
                end
                else
                begin
                    want = expected_grads.pop_front();
                    bad += field_differs("first_bin_degrees",
                                         int'(want.first_bin_degrees),
                                         int'(grad.first_bin_degrees));
                    bad += field_differs("second_bin_degrees",
                                         int'(want.second_bin_degrees),
                                         int'(grad.second_bin_degrees));
                    bad += field_differs("first_magnitude",
                                         int'(want.first_magnitude),
                                         int'(grad.first_magnitude));
                    bad += field_differs("second_magnitude",
                                         int'(want.second_magnitude),
                                         int'(grad.second_magnitude));
                    compared <= compared + 1;
                end
            end
            if (pix_valid && !pix_stall)
                expected_grads.push_back(split_gradient(pix));
            if (bad != 0)
                errors <= errors + 1;
            outstanding <= expected_grads.size();
        end
    end

endmodule

FILE: verif/hog_gradient_bin_split_tb.sv
module hog_gradient_bin_split_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 210;
    localparam int TAIL_CYCLES    = 8;

    logic            clk;
    logic            rst_n;
    logic            pix_valid;
    logic            pix_stall;
    hgbs_pkg::pix_t  pix;
    logic            grad_valid;
    logic            grad_stall;
    hgbs_pkg::grad_t grad;

    int idle_pct      = 0;
    int stall_pct     = 0;
    int requests_sent = 0;
    int quiet_cycles  = 0;
    int errors;
    int outstanding;
    int compared;

    int directed_dx[] = '{0, 255, 0, -255, -10, 20, 255, 1, 10, 10, 10, 10,
                          91, 97, 230, 244, 93, 1, 255, 3};
    int directed_dy[] = '{0, 0, 255, -255, 20, -10, 255, 3, 12, 11, 5, 1,
                          250, 56, 193, 43, 255, 0, 1, -3};
    int idle_by_phase[]  = '{0, 62, 0, 16};
    int stall_by_phase[] = '{0, 0, 62, 16};

    hog_gradient_bin_split u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix        (pix),
        .grad_valid (grad_valid),
        .grad_stall (grad_stall),
        .grad       (grad)
    );

    gradient_split_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .pix         (pix),
        .grad_valid  (grad_valid),
        .grad_stall  (grad_stall),
        .grad        (grad),
        .errors      (errors),
        .outstanding (outstanding),
        .compared    (compared)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(negedge clk)
        grad_stall <= rst_n && (int'($urandom_range(0, 99)) < stall_pct);

    always @(posedge clk)
    begin
        if ((pix_valid && !pix_stall) || (grad_valid && !grad_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // dx and dy may be negative; the pixels are placed at a random level
    function automatic hgbs_pkg::pix_t pix_from_diff(input int dx, input int dy);
        hgbs_pkg::pix_t p;
        int             base;
        base = int'($urandom_range(0, 255 - ((dx < 0) ? -dx : dx)));
        p.left_pixel  = 8'((dx >= 0) ? base : base - dx);
        p.right_pixel = 8'((dx >= 0) ? base + dx : base);
        base = int'($urandom_range(0, 255 - ((dy < 0) ? -dy : dy)));
        p.upper_pixel = 8'((dy >= 0) ? base : base - dy);
        p.lower_pixel = 8'((dy >= 0) ? base + dy : base);
        return p;
    endfunction

    function automatic hgbs_pkg::pix_t random_pixel();
        int mode;
        int dx;
        int dy;
        int k;
        int num;
        int den;
        mode = int'($urandom_range(0, 9));
        if (mode < 3)
            return hgbs_pkg::pix_t'($urandom);
        if (mode < 7)
        begin
            dx = int'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255));
            dy = int'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255));
            return pix_from_diff(dx, dy);
        end
        // land near one of the ratio thresholds
        k = int'($urandom_range(0, 3));
        num = (k == 0) ? 91  : (k == 1) ? 193 : (k == 2) ? 97 : 244;
        den = (k == 0) ? 250 : (k == 1) ? 230 : (k == 2) ? 56 : 43;
        dx = int'($urandom_range(1, (255 * num / den > 255) ? 255 : 255 * num / den));
        dy = dx * den / num + int'($urandom_range(0, 2)) - 1;
        if (dy < 0)
            dy = 0;
        if (dy > 255)
            dy = 255;
        return pix_from_diff(dx, dy);
    endfunction

    task automatic send_request(input hgbs_pkg::pix_t p);
        while (int'($urandom_range(0, 99)) < idle_pct)
        begin
            pix_valid <= 1'b0;
            @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= p;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        requests_sent++;
        @(negedge clk);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        pix_valid  = 1'b0;
        pix        = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_request('0);
        send_request('1);
        foreach (directed_dx[i])
            send_request(pix_from_diff(directed_dx[i], directed_dy[i]));

        foreach (idle_by_phase[ph])
        begin
            idle_pct  = idle_by_phase[ph];
            stall_pct = stall_by_phase[ph];
            repeat (PHASE_ITEMS)
                send_request(random_pixel());
        end
        pix_valid <= 1'b0;

        wait (outstanding == 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d pixel requests: directed edges, then free-running, sender gaps,",
                 requests_sent);
        $display("receiver stalls and mixed pacing; %0d gradient results compared",
                 compared);
        if (errors == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
